>>> hdl/mbs_pkg.sv
// shared types, constants and helpers of the multichannel barrier synchroniser
package mbs_pkg;

    localparam int NUM_CHANNELS  = 3;
    localparam int COUNT_MODULUS = 100;
    localparam int COUNT_W       = 7;
    localparam int CH_IDX_W      = $clog2(NUM_CHANNELS);
    localparam int PASS_MAX      = NUM_CHANNELS + 2;
    localparam int PASS_W        = $clog2(PASS_MAX + 1);

    typedef logic [COUNT_W-1:0]                    count_t;
    typedef logic [NUM_CHANNELS-1:0]               chan_t;
    typedef logic [CH_IDX_W-1:0]                   ch_idx_t;
    typedef logic [PASS_W-1:0]                     pass_t;
    typedef logic [NUM_CHANNELS-1:0][COUNT_W-1:0]  row_t;

    // per-visit flags of the channel being visited
    typedef struct packed {
        logic req;
        logic req_prev;
        logic check;
        logic done_prev;
    } visit_ctl_t;

    // outcome of one channel visit
    typedef struct packed {
        row_t row;
        logic write;
        logic done_clr;
        logic done_set;
    } visit_res_t;

    // increment with wrap at the counter modulus
    function automatic count_t inc_mod(count_t v);
        count_t r;
        if (v == count_t'(COUNT_MODULUS - 1)) begin
            r = '0;
        end else begin
            r = v + count_t'(1);
        end
        return r;
    endfunction

endpackage

>>> hdl/mbs_visit.sv
// channel visit unit: row load, mask compare and generation bump for one channel
module mbs_visit (
    input  mbs_pkg::row_t       row_in,
    input  mbs_pkg::row_t       diag_in,
    input  mbs_pkg::chan_t      mask_in,
    input  mbs_pkg::ch_idx_t    ch_in,
    input  mbs_pkg::visit_ctl_t ctl_in,
    output mbs_pkg::visit_res_t res_out
);

    mbs_pkg::row_t   row_eff;
    mbs_pkg::count_t gen;
    logic            rising;
    logic            ok;
    logic            release_ch;
    logic            bump;

    // rising request reloads the row from the diagonal plus one
    always_comb begin
        rising  = ctl_in.req && !ctl_in.req_prev;
        row_eff = row_in;
        ok      = 1'b1;
        for (int i = 0; i < mbs_pkg::NUM_CHANNELS; i++) begin
            if (rising) begin
                row_eff[i] = mbs_pkg::inc_mod(diag_in[i]);
            end
        end
        // every masked peer must have reached the expected generation
        for (int i = 0; i < mbs_pkg::NUM_CHANNELS; i++) begin
            if ((mbs_pkg::ch_idx_t'(i) != ch_in) && mask_in[i] &&
                (row_eff[i] != diag_in[i])) begin
                ok = 1'b0;
            end
        end
    end

    // first release bumps the generation across the whole row
    always_comb begin
        release_ch = ctl_in.req && ctl_in.check && ok;
        bump       = release_ch && !ctl_in.done_prev;
        gen        = mbs_pkg::inc_mod(row_eff[ch_in]);
        res_out.row = row_eff;
        if (bump) begin
            for (int i = 0; i < mbs_pkg::NUM_CHANNELS; i++) begin
                res_out.row[i] = gen;
            end
        end
        res_out.write    = ctl_in.req;
        res_out.done_clr = rising;
        res_out.done_set = release_ch;
    end

endmodule

>>> hdl/multichannel_barrier_sync.sv
// multichannel barrier synchroniser top level: sequencer, state and result register
// operation: the sequencer steps the channel visit unit over every channel in every pass,
//   2 to 5 passes, then loads the result register; a transaction with clear_all set goes
//   straight to the result register. One transaction is taken at a time: s_ready stays low
//   until the result register takes the result, as the single visit unit serves every channel
// reset: synchronous active-low aresetn zeroes counters and flags, sets all masks
module multichannel_barrier_sync (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_clear_all,
    input  mbs_pkg::chan_t           s_request_bits,
    output logic                     m_valid,
    input  logic                     m_ready,
    output mbs_pkg::chan_t           m_request_after,
    output mbs_pkg::chan_t           m_done_bits,
    output logic                     m_all_done,
    output mbs_pkg::count_t          m_count_ch0,
    output mbs_pkg::count_t          m_count_ch1,
    output mbs_pkg::count_t          m_count_ch2,
    input  logic                     cfg_wr_en,
    input  mbs_pkg::ch_idx_t         cfg_index,
    input  mbs_pkg::chan_t           cfg_wr_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    localparam int CH_IDX_W_P1 = mbs_pkg::CH_IDX_W + 1;

    logic [1:0]          state_reg;
    mbs_pkg::ch_idx_t    ch_reg;
    mbs_pkg::pass_t      pass_reg;
    mbs_pkg::row_t       cm_reg [mbs_pkg::NUM_CHANNELS];
    mbs_pkg::chan_t      mask_reg [mbs_pkg::NUM_CHANNELS];
    mbs_pkg::chan_t      req_reg;
    mbs_pkg::chan_t      req_prev_reg;
    mbs_pkg::chan_t      check_reg;
    mbs_pkg::chan_t      done_reg;
    mbs_pkg::chan_t      done_prev_reg;
    mbs_pkg::chan_t      busy_reg;
    mbs_pkg::chan_t      done_next;
    mbs_pkg::chan_t      req_masked;
    mbs_pkg::chan_t      unlock;
    mbs_pkg::pass_t      pass_next;
    mbs_pkg::row_t       diag;
    mbs_pkg::visit_ctl_t vctl;
    mbs_pkg::visit_res_t vres;
    logic                pass_end;
    logic                again;
    logic                out_free;

    logic                m_valid_reg;
    mbs_pkg::chan_t      m_request_after_reg;
    mbs_pkg::chan_t      m_done_bits_reg;
    logic                m_all_done_reg;
    mbs_pkg::count_t     m_count_ch0_reg;
    mbs_pkg::count_t     m_count_ch1_reg;
    mbs_pkg::count_t     m_count_ch2_reg;

    // diagonal generations and masked request
    always_comb begin
        for (int i = 0; i < mbs_pkg::NUM_CHANNELS; i++) begin
            diag[i]       = cm_reg[i][i];
            req_masked[i] = s_request_bits[i] && (mask_reg[i] != '0);
        end
    end

    // flags of the channel under visit
    always_comb begin
        vctl.req       = req_reg[ch_reg];
        vctl.req_prev  = req_prev_reg[ch_reg];
        vctl.check     = check_reg[ch_reg];
        vctl.done_prev = done_prev_reg[ch_reg];
    end

    mbs_visit u_visit (
        .row_in  (cm_reg[ch_reg]),
        .diag_in (diag),
        .mask_in (mask_reg[ch_reg]),
        .ch_in   (ch_reg),
        .ctl_in  (vctl),
        .res_out (vres)
    );

    // done flags after this visit and end-of-pass decision
    always_comb begin
        done_next = done_reg;
        if (vres.done_clr) begin
            done_next[ch_reg] = 1'b0;
        end
        if (vres.done_set) begin
            done_next[ch_reg] = 1'b1;
        end
        pass_end  = (ch_reg == mbs_pkg::ch_idx_t'(mbs_pkg::NUM_CHANNELS - 1));
        unlock    = done_next & ~done_prev_reg;
        pass_next = pass_reg + mbs_pkg::pass_t'(1);
        again     = ((unlock != '0) || (pass_reg == '0)) &&
                    (pass_next < mbs_pkg::pass_t'(mbs_pkg::PASS_MAX));
        out_free  = !m_valid_reg || m_ready;
    end

    // sequencer and barrier state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ch_reg        <= '0;
            pass_reg      <= '0;
            req_reg       <= '0;
            req_prev_reg  <= '0;
            check_reg     <= '0;
            done_reg      <= '0;
            done_prev_reg <= '0;
            busy_reg      <= '0;
            for (int i = 0; i < mbs_pkg::NUM_CHANNELS; i++) begin
                cm_reg[i]   <= '0;
                mask_reg[i] <= '1;
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        if (s_clear_all) begin
                            req_reg       <= s_request_bits;
                            req_prev_reg  <= '0;
                            check_reg     <= '0;
                            done_reg      <= '0;
                            done_prev_reg <= '0;
                            busy_reg      <= '0;
                            for (int i = 0; i < mbs_pkg::NUM_CHANNELS; i++) begin
                                cm_reg[i]   <= '0;
                                mask_reg[i] <= '1;
                            end
                            state_reg <= ST_FINISH;
                        end else begin
                            req_reg   <= req_masked;
                            check_reg <= ~busy_reg;
                            ch_reg    <= '0;
                            pass_reg  <= '0;
                            state_reg <= ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    busy_reg[ch_reg] <= req_reg[ch_reg];
                    done_reg         <= done_next;
                    if (vres.write) begin
                        cm_reg[ch_reg] <= vres.row;
                    end
                    if (pass_end) begin
                        req_reg       <= req_reg & ~done_next;
                        req_prev_reg  <= req_reg & ~done_next;
                        check_reg     <= '1;
                        done_prev_reg <= done_next;
                        ch_reg        <= '0;
                        pass_reg      <= pass_next;
                        if (!again) begin
                            state_reg <= ST_FINISH;
                        end
                    end else begin
                        ch_reg <= ch_reg + mbs_pkg::ch_idx_t'(1);
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            // register writes, indexes past the list are dropped
            if (cfg_wr_en && ({1'b0, cfg_index} < (CH_IDX_W_P1)'(mbs_pkg::NUM_CHANNELS))) begin
                mask_reg[cfg_index] <= cfg_wr_data;
            end
        end
    end

    // result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_FINISH) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_FINISH) && out_free) begin
            m_request_after_reg <= req_reg;
            m_done_bits_reg     <= done_reg;
            m_all_done_reg      <= (done_reg == '1);
            m_count_ch0_reg     <= diag[0];
            m_count_ch1_reg     <= diag[1];
            m_count_ch2_reg     <= diag[2];
        end
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_request_after = m_request_after_reg;
    assign m_done_bits     = m_done_bits_reg;
    assign m_all_done      = m_all_done_reg;
    assign m_count_ch0     = m_count_ch0_reg;
    assign m_count_ch1     = m_count_ch1_reg;
    assign m_count_ch2     = m_count_ch2_reg;

endmodule

>>> hdl/mbs_checker.sv
// port-level checker of the barrier synchroniser and its bind
module mbs_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input logic            m_valid,
    input logic            m_ready,
    input mbs_pkg::chan_t  m_request_after,
    input mbs_pkg::chan_t  m_done_bits,
    input logic            m_all_done,
    input mbs_pkg::count_t m_count_ch0,
    input mbs_pkg::count_t m_count_ch1,
    input mbs_pkg::count_t m_count_ch2
);

    // a stalled result holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_request_after) &&
            $stable(m_done_bits) && $stable(m_count_ch0) &&
            $stable(m_count_ch1) && $stable(m_count_ch2)))
        else $error("result changed while stalled");

    // one transaction in work at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while busy");

    // all-done agrees with the done bits
    a_all: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_all_done == (m_done_bits == '1)))
        else $error("all_done inconsistent");

    // released channels have their request cleared
    a_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_request_after & m_done_bits) == '0))
        else $error("request left on a released channel");

    // generations stay below the modulus
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_count_ch0 < mbs_pkg::count_t'(mbs_pkg::COUNT_MODULUS)) &&
            (m_count_ch1 < mbs_pkg::count_t'(mbs_pkg::COUNT_MODULUS)) &&
            (m_count_ch2 < mbs_pkg::count_t'(mbs_pkg::COUNT_MODULUS))))
        else $error("counter out of range");

endmodule

bind multichannel_barrier_sync mbs_checker u_mbs_checker (.*);

>>> dv/tb_top.sv
// self-checking testbench of the multichannel barrier synchroniser
module tb_top;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int QUIET_FROM    = 3000;
    localparam int QUIET_TO      = 6000;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AFTER    = 120;
    localparam int RANDOM_TICKS  = 75;
    localparam int NUM_PHASES    = 7;

    // register indexes of the configuration port
    localparam mbs_pkg::ch_idx_t REG_MASK_CH0 = mbs_pkg::ch_idx_t'(0);
    localparam mbs_pkg::ch_idx_t REG_MASK_CH1 = mbs_pkg::ch_idx_t'(1);
    localparam mbs_pkg::ch_idx_t REG_MASK_CH2 = mbs_pkg::ch_idx_t'(2);
    localparam mbs_pkg::ch_idx_t REG_UNUSED   = mbs_pkg::ch_idx_t'(3);

    typedef struct packed {
        logic           clear_all;
        mbs_pkg::chan_t request_bits;
    } scan_tick_t;

    typedef struct packed {
        mbs_pkg::chan_t  request_after;
        mbs_pkg::chan_t  done_bits;
        logic            all_done;
        mbs_pkg::count_t count_ch0;
        mbs_pkg::count_t count_ch1;
        mbs_pkg::count_t count_ch2;
    } sync_result_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic             s_clear_all = 1'b0;
    mbs_pkg::chan_t   s_request_bits = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    mbs_pkg::chan_t   m_request_after;
    mbs_pkg::chan_t   m_done_bits;
    logic             m_all_done;
    mbs_pkg::count_t  m_count_ch0;
    mbs_pkg::count_t  m_count_ch1;
    mbs_pkg::count_t  m_count_ch2;
    logic             cfg_wr_en = 1'b0;
    mbs_pkg::ch_idx_t cfg_index = '0;
    mbs_pkg::chan_t   cfg_wr_data = '0;

    multichannel_barrier_sync dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_clear_all     (s_clear_all),
        .s_request_bits  (s_request_bits),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_request_after (m_request_after),
        .m_done_bits     (m_done_bits),
        .m_all_done      (m_all_done),
        .m_count_ch0     (m_count_ch0),
        .m_count_ch1     (m_count_ch1),
        .m_count_ch2     (m_count_ch2),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data)
    );

    always #4 aclk = ~aclk;

    scan_tick_t     tick_queue[$];
    sync_result_t   expected_results[$];
    int             mismatch_count = 0;
    int             results_seen = 0;
    int             cycle_count = 0;
    bit             in_fire = 1'b0;
    mbs_pkg::chan_t walk_req = '0;

    // shadow of the synchroniser state
    mbs_pkg::count_t gen_matrix[mbs_pkg::NUM_CHANNELS][mbs_pkg::NUM_CHANNELS];
    mbs_pkg::chan_t  wait_mask[mbs_pkg::NUM_CHANNELS];
    mbs_pkg::chan_t  done_q, done_prev_q, busy_q, req_prev_q, check_q;

    function automatic mbs_pkg::count_t next_gen(mbs_pkg::count_t v);
        return mbs_pkg::count_t'((int'(v) + 1) % mbs_pkg::COUNT_MODULUS);
    endfunction

    function automatic void clear_sync_state();
        for (int a = 0; a < mbs_pkg::NUM_CHANNELS; a++) begin
            wait_mask[a] = '1;
            for (int b = 0; b < mbs_pkg::NUM_CHANNELS; b++) gen_matrix[a][b] = '0;
        end
        done_q = '0;
        done_prev_q = '0;
        busy_q = '0;
        req_prev_q = '0;
        check_q = '0;
    endfunction

    // one scan tick: repeated passes over the channels until no new release or the pass limit
    function automatic sync_result_t sync_tick(logic clr, mbs_pkg::chan_t req_in);
        sync_result_t    r;
        mbs_pkg::chan_t  req;
        mbs_pkg::chan_t  unlock;
        int              passes;
        bit              again;
        bit              ok;
        mbs_pkg::count_t g;
        r = '0;
        req = req_in;
        if (clr) begin
            clear_sync_state();
            r.request_after = req_in;
            return r;
        end
        for (int c = 0; c < mbs_pkg::NUM_CHANNELS; c++)
            if (wait_mask[c] == '0) req[c] = 1'b0;
        check_q = ~busy_q;
        passes = 0;
        do begin
            for (int c = 0; c < mbs_pkg::NUM_CHANNELS; c++) begin
                busy_q[c] = req[c];
                if (req[c]) begin
                    // rising request loads the row from the diagonal plus one
                    if (!req_prev_q[c]) begin
                        done_q[c] = 1'b0;
                        for (int i = 0; i < mbs_pkg::NUM_CHANNELS; i++)
                            gen_matrix[c][i] = next_gen(gen_matrix[i][i]);
                    end
                    if (check_q[c]) begin
                        ok = 1'b1;
                        for (int i = 0; i < mbs_pkg::NUM_CHANNELS; i++)
                            if (i != c && wait_mask[c][i] &&
                                gen_matrix[c][i] != gen_matrix[i][i]) ok = 1'b0;
                        if (ok) begin
                            done_q[c] = 1'b1;
                            // first release bumps the generation across the row
                            if (!done_prev_q[c]) begin
                                g = next_gen(gen_matrix[c][c]);
                                for (int i = 0; i < mbs_pkg::NUM_CHANNELS; i++)
                                    gen_matrix[c][i] = g;
                            end
                        end
                    end
                end
            end
            req = req & ~done_q;
            req_prev_q = req;
            check_q = '1;
            unlock = done_q & ~done_prev_q;
            again = (unlock != '0) || (passes == 0);
            passes++;
            done_prev_q = done_q;
        end while (again && passes < mbs_pkg::NUM_CHANNELS + 2);
        r.request_after = req;
        r.done_bits = done_q;
        r.all_done = (done_q == '1);
        r.count_ch0 = gen_matrix[0][0];
        r.count_ch1 = gen_matrix[1][1];
        r.count_ch2 = gen_matrix[2][2];
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch in %s at result %0d: got %0d, expected %0d",
                 field, results_seen, got, want);
        mismatch_count++;
    endtask

    function automatic bit idle_now();
        if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 1'b0;
        return $urandom_range(99) < 9;
    endfunction

    // sampling at the rising edge: input acceptance, result checking, timeout
    always @(posedge aclk) begin
        sync_result_t want;
        cycle_count <= cycle_count + 1;
        in_fire = s_valid && s_ready;
        if (in_fire) expected_results.push_back(sync_tick(s_clear_all, s_request_bits));
        if (m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, request_after",
                                int'(m_request_after), 0);
            end else begin
                want = expected_results.pop_front();
                if (m_request_after !== want.request_after)
                    report_mismatch("request_after", int'(m_request_after),
                                    int'(want.request_after));
                if (m_done_bits !== want.done_bits)
                    report_mismatch("done_bits", int'(m_done_bits), int'(want.done_bits));
                if (m_all_done !== want.all_done)
                    report_mismatch("all_done", int'(m_all_done), int'(want.all_done));
                if (m_count_ch0 !== want.count_ch0)
                    report_mismatch("count_ch0", int'(m_count_ch0), int'(want.count_ch0));
                if (m_count_ch1 !== want.count_ch1)
                    report_mismatch("count_ch1", int'(m_count_ch1), int'(want.count_ch1));
                if (m_count_ch2 !== want.count_ch2)
                    report_mismatch("count_ch2", int'(m_count_ch2), int'(want.count_ch2));
            end
            results_seen++;
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // input driver: holds a transaction until accepted, then idles or sends the next
    always @(negedge aclk) begin
        scan_tick_t t;
        logic       v;
        t = '{clear_all: s_clear_all, request_bits: s_request_bits};
        v = s_valid;
        if (!aresetn) begin
            v = 1'b0;
        end else if (!s_valid || in_fire) begin
            v = 1'b0;
            if (tick_queue.size() != 0 && !idle_now()) begin
                t = tick_queue.pop_front();
                v = 1'b1;
            end
        end
        s_valid <= v;
        s_clear_all <= t.clear_all;
        s_request_bits <= t.request_bits;
    end

    // result receiver: random stalls plus one long hold-off
    always @(negedge aclk) begin
        int hold_left;
        bit hold_done;
        logic rdy;
        if (!aresetn) begin
            rdy = 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
            rdy = 1'b0;
        end else begin
            rdy = !idle_now();
        end
        m_ready <= rdy;
    end

    task automatic push_tick(input logic clr, input mbs_pkg::chan_t req);
        tick_queue.push_back('{clear_all: clr, request_bits: req});
    endtask

    // mostly slowly changing request patterns, some noise and clear ticks
    task automatic gen_ticks(input int n);
        int r;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 3) begin
                push_tick(1'b1, mbs_pkg::chan_t'($urandom_range(7)));
                walk_req = '0;
            end else if (r < 15) begin
                push_tick(1'b0, mbs_pkg::chan_t'($urandom_range(7)));
            end else begin
                for (int c = 0; c < mbs_pkg::NUM_CHANNELS; c++)
                    if ($urandom_range(99) < 20) walk_req[c] = ~walk_req[c];
                push_tick(1'b0, walk_req);
            end
        end
    endtask

    task automatic write_reg(input mbs_pkg::ch_idx_t idx, input mbs_pkg::chan_t val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        if (int'(idx) < mbs_pkg::NUM_CHANNELS) wait_mask[idx] = val;
    endtask

    task automatic wait_drained();
        while (tick_queue.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    mbs_pkg::chan_t phase_masks[NUM_PHASES][mbs_pkg::NUM_CHANNELS] = '{
        '{3'd7, 3'd7, 3'd7}, '{3'd0, 3'd0, 3'd0}, '{3'd1, 3'd2, 3'd4},
        '{3'd6, 3'd5, 3'd3}, '{3'd3, 3'd6, 3'd5}, '{3'd2, 3'd0, 3'd7},
        '{3'd0, 3'd4, 3'd1}
    };

    initial begin
        clear_sync_state();
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // directed ticks with the reset masks
        push_tick(1'b1, 3'd7);
        push_tick(1'b1, 3'd0);
        repeat (4) push_tick(1'b0, 3'd7);
        push_tick(1'b0, 3'd0);
        repeat (3) push_tick(1'b0, 3'd1);
        repeat (3) push_tick(1'b0, 3'd3);
        push_tick(1'b0, 3'd0);
        repeat (2) push_tick(1'b0, 3'd6);
        repeat (3) push_tick(1'b0, 3'd7);
        push_tick(1'b1, 3'd5);
        push_tick(1'b0, 3'd2);
        push_tick(1'b0, 3'd4);
        push_tick(1'b0, 3'd0);
        wait_drained();

        // configuration phases, each followed by random ticks
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(REG_MASK_CH0, phase_masks[p][0]);
            write_reg(REG_MASK_CH1, phase_masks[p][1]);
            write_reg(REG_MASK_CH2, phase_masks[p][2]);
            if (p % 2 == 0) write_reg(REG_UNUSED, mbs_pkg::chan_t'($urandom_range(7)));
            @(negedge aclk);
            cfg_wr_en <= 1'b0;
            if (p == 2) begin
                // channels waiting only on themselves release at once
                repeat (2) push_tick(1'b0, 3'd7);
            end
            gen_ticks(RANDOM_TICKS);
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/mbs_pkg.sv
hdl/mbs_visit.sv
hdl/multichannel_barrier_sync.sv
hdl/mbs_checker.sv
dv/tb_top.sv
